### hw/rtl/cm3a_pkg.sv
package cm3a_pkg;

    // Operation codes carried by the ninth word of a run
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_CONJ  = 3'd3;
    localparam logic [2:0] OP_TRACE = 3'd4;
    localparam logic [2:0] OP_DET   = 3'd5;
    localparam logic [2:0] OP_SCALE = 3'd6;
    localparam logic [2:0] OP_BAD   = 3'd7;  // unused code: run is dropped

    localparam int PORT_BITS = 32;
    localparam int IDX_BITS  = 4;

    typedef struct packed {
        logic [2:0]                  opcode;
        logic signed [PORT_BITS-1:0] a_re;
        logic signed [PORT_BITS-1:0] a_im;
        logic signed [PORT_BITS-1:0] b_re;
        logic signed [PORT_BITS-1:0] b_im;
        logic signed [PORT_BITS-1:0] s_re;
        logic signed [PORT_BITS-1:0] s_im;
    } t_in_word;

    typedef struct packed {
        logic signed [PORT_BITS-1:0] res_re;
        logic signed [PORT_BITS-1:0] res_im;
        logic                        last;
        logic                        saturated;
    } t_out_word;

    // One complex matrix element as stored
    typedef struct packed {
        logic [PORT_BITS-1:0] re;
        logic [PORT_BITS-1:0] im;
    } t_cval;

    // Job handed from the loader to the compute engine
    typedef struct packed {
        logic [2:0]           op;
        logic [PORT_BITS-1:0] s_re;
        logic [PORT_BITS-1:0] s_im;
        logic                 bank;
    } t_job;

    // Element read request from the engine to the stores
    typedef struct packed {
        logic                bank;
        logic [IDX_BITS-1:0] a_idx;
        logic [IDX_BITS-1:0] b_idx;
    } t_rd_req;

    // Element indexes {i, j, k} of the six determinant terms; terms 3..5 subtract
    function automatic logic [3*IDX_BITS-1:0] det_tri(input logic [2:0] n);
        logic [3*IDX_BITS-1:0] t;
        case (n)
            3'd0:    t = {4'd0, 4'd4, 4'd8};
            3'd1:    t = {4'd1, 4'd5, 4'd6};
            3'd2:    t = {4'd2, 4'd3, 4'd7};
            3'd3:    t = {4'd2, 4'd4, 4'd6};
            3'd4:    t = {4'd1, 4'd3, 4'd8};
            3'd5:    t = {4'd0, 4'd5, 4'd7};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

### hw/rtl/cm3a_in_if.sv
interface cm3a_in_if import cm3a_pkg::*; ;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/cm3a_out_if.sv
interface cm3a_out_if import cm3a_pkg::*; ;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/complex_matrix3_arithmetic.sv
// Channel | Dir | Word                                      | Notes
// i_in    | in  | opcode, a_re, a_im, b_re, b_im, s_re, s_im | nine words per run, row-major
// o_out   | out | res_re, res_im, last, saturated           | nine words or one per valid run
//
// Loads take one word per cycle unless the queue is full; after the ninth word a job is queued and the engine runs.
// Engine run time is set by the one shared multiplier and one read port per store.
// Two store banks: the next run loads while the previous one computes; loading stalls only
// when the queue holds two runs, the one computing and one waiting. A stalled output holds the engine in its emit step.
// Reset is synchronous and clears counters, queue and output valid.
module complex_matrix3_arithmetic import cm3a_pkg::*; #(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cm3a_in_if.sink    i_in,
    cm3a_out_if.source o_out
);

    logic    push, full, job_valid, pop;
    t_job    job_in, job_head;
    t_rd_req rd;
    t_cval   a_q, b_q;

    cm3a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in),
        .i_rd    (rd),
        .o_a_q   (a_q),
        .o_b_q   (b_q)
    );

    cm3a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .o_valid (job_valid),
        .o_head  (job_head),
        .i_pop   (pop)
    );

    cm3a_back #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_head),
        .o_pop       (pop),
        .o_rd        (rd),
        .i_a_q       (a_q),
        .i_b_q       (b_q),
        .o_out       (o_out)
    );

endmodule

### hw/rtl/cm3a_front.sv
module cm3a_front import cm3a_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cm3a_in_if.sink i_in,
    input  logic    i_full,
    output logic    o_push,
    output t_job    o_job,
    input  t_rd_req i_rd,
    output t_cval   o_a_q,
    output t_cval   o_b_q
);

    // Two banks of sixteen entries each (nine used), addressed {bank, index}
    t_cval r_a_mem [0:2**(IDX_BITS+1)-1];
    t_cval r_b_mem [0:2**(IDX_BITS+1)-1];

    logic [IDX_BITS-1:0] r_load_cnt;
    logic                r_bank;
    logic                accept;
    logic                last_load;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign last_load  = (r_load_cnt == IDX_BITS'(8));

    assign o_push     = accept && last_load;
    assign o_job.op   = i_in.data.opcode;
    assign o_job.s_re = i_in.data.s_re;
    assign o_job.s_im = i_in.data.s_im;
    assign o_job.bank = r_bank;

    // Load counter and bank toggle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_bank     <= 1'b0;
        end else if (accept) begin
            if (last_load) begin
                r_load_cnt <= '0;
                r_bank     <= !r_bank;
            end else begin
                r_load_cnt <= r_load_cnt + 1'b1;
            end
        end
    end

    // Element stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_mem[{r_bank, r_load_cnt}] <= '{re: i_in.data.a_re, im: i_in.data.a_im};
            r_b_mem[{r_bank, r_load_cnt}] <= '{re: i_in.data.b_re, im: i_in.data.b_im};
        end
        o_a_q <= r_a_mem[{i_rd.bank, i_rd.a_idx}];
        o_b_q <= r_b_mem[{i_rd.bank, i_rd.b_idx}];
    end

endmodule

### hw/rtl/cm3a_queue.sv
module cm3a_queue import cm3a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_head,
    input  logic i_pop
);

    // Two-entry job queue
    t_job       r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### hw/rtl/cm3a_back.sv
module cm3a_back import cm3a_pkg::*; #(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output t_rd_req     o_rd,
    input  t_cval       i_a_q,
    input  t_cval       i_b_q,
    cm3a_out_if.source  o_out
);

    localparam int EFF    = (WORD_BITS < PORT_BITS) ? WORD_BITS : PORT_BITS;
    localparam int PROD_W = 2 * EFF;
    localparam int ACC_W  = 2 * EFF + 4;
    localparam logic signed [ACC_W-1:0] WMAX = ACC_W'((65'sd1 <<< (EFF - 1)) - 65'sd1);
    localparam logic signed [ACC_W-1:0] WMIN = -WMAX - ACC_W'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_LD1  = 3'd2;
    localparam logic [2:0] S_LD2  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_TSAT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_st;
    logic [1:0] r_row, r_col, r_k, r_m;
    logic [2:0] r_n;
    logic       r_ph;
    logic       r_flag;
    logic signed [EFF-1:0]    r_x_re, r_x_im, r_y_re, r_y_im;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im, r_tac_re, r_tac_im;
    logic                     r_ov;
    t_out_word                r_o;

    logic signed [EFF-1:0]    a_re, a_im, b_re, b_im, mul_a, mul_b;
    logic signed [ACC_W-1:0]  a_re_x, a_im_x, b_re_x, b_im_x;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  prod_x, addend;
    logic [3*IDX_BITS-1:0]    tri_idx;
    logic [IDX_BITS-1:0]      a_idx, b_idx;
    logic                     is_det, sub, free, last_res, bad_op;
    logic [EFF:0]             sat_ar, sat_ai, sat_tr, sat_ti;

    // Clip to the word range; top bit flags a clip
    function automatic logic [EFF:0] sat_f(input logic signed [ACC_W-1:0] v);
        logic [EFF:0] r;
        if (v > WMAX) begin
            r = {1'b1, WMAX[EFF-1:0]};
        end else if (v < WMIN) begin
            r = {1'b1, WMIN[EFF-1:0]};
        end else begin
            r = {1'b0, v[EFF-1:0]};
        end
        return r;
    endfunction

    // Operand views, sign-extended from the word width
    assign a_re   = i_a_q.re[EFF-1:0];
    assign a_im   = i_a_q.im[EFF-1:0];
    assign b_re   = i_b_q.re[EFF-1:0];
    assign b_im   = i_b_q.im[EFF-1:0];
    assign a_re_x = ACC_W'(a_re);
    assign a_im_x = ACC_W'(a_im);
    assign b_re_x = ACC_W'(b_re);
    assign b_im_x = ACC_W'(b_im);

    assign is_det  = (i_job.op == OP_DET);
    assign bad_op  = (i_job.op > OP_SCALE);
    assign tri_idx = det_tri(r_n);

    // Store read addresses
    always_comb begin
        a_idx = 4'(r_row) * 4'd3 + 4'(r_col);
        b_idx = a_idx;
        case (i_job.op)
            OP_MUL: begin
                a_idx = 4'(r_row) * 4'd3 + 4'(r_k);
                b_idx = 4'(r_k) * 4'd3 + 4'(r_col);
            end
            OP_CONJ:  a_idx = 4'(r_col) * 4'd3 + 4'(r_row);
            OP_TRACE: a_idx = {r_k, 2'b00};
            OP_DET: begin
                if (r_st == S_LD1) begin
                    a_idx = tri_idx[2*IDX_BITS-1:IDX_BITS];
                end else if (r_ph) begin
                    a_idx = tri_idx[IDX_BITS-1:0];
                end else begin
                    a_idx = tri_idx[3*IDX_BITS-1:2*IDX_BITS];
                end
            end
            default: ;
        endcase
    end

    assign o_rd.bank  = i_job.bank;
    assign o_rd.a_idx = a_idx;
    assign o_rd.b_idx = b_idx;

    // Shared multiplier operand select: re*re, im*im, re*im, im*re
    always_comb begin
        case (r_m)
            2'd0:    begin mul_a = r_x_re; mul_b = r_y_re; end
            2'd1:    begin mul_a = r_x_im; mul_b = r_y_im; end
            2'd2:    begin mul_a = r_x_re; mul_b = r_y_im; end
            default: begin mul_a = r_x_im; mul_b = r_y_re; end
        endcase
    end

    // Floor-shifted product and its sign in the sum
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign prod_x  = ACC_W'(prod_sh);
    assign sub     = (r_m == 2'd1) ^ (is_det && r_ph && (r_n >= 3'd3));
    assign addend  = sub ? -prod_x : prod_x;

    assign sat_ar = sat_f(r_acc_re);
    assign sat_ai = sat_f(r_acc_im);
    assign sat_tr = sat_f(r_tac_re);
    assign sat_ti = sat_f(r_tac_im);

    assign free     = !r_ov || o_out.ready;
    assign last_res = (i_job.op == OP_TRACE) || is_det || (r_row == 2'd2 && r_col == 2'd2);
    assign o_pop    = (r_st == S_OUT && free && last_res)
                   || (r_st == S_IDLE && i_job_valid && bad_op);

    assign o_out.valid = r_ov;
    assign o_out.data  = r_o;

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    r_row    <= '0;
                    r_col    <= '0;
                    r_k      <= '0;
                    r_n      <= '0;
                    r_ph     <= 1'b0;
                    r_m      <= '0;
                    r_flag   <= 1'b0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                    r_tac_re <= '0;
                    r_tac_im <= '0;
                    if (i_job_valid && !bad_op) begin
                        r_st <= S_RD1;
                    end
                end
                S_RD1: r_st <= S_LD1;
                S_LD1: begin
                    r_m <= '0;
                    case (i_job.op)
                        OP_ADD: begin
                            r_acc_re <= a_re_x + b_re_x;
                            r_acc_im <= a_im_x + b_im_x;
                            r_st     <= S_OUT;
                        end
                        OP_SUB: begin
                            r_acc_re <= a_re_x - b_re_x;
                            r_acc_im <= a_im_x - b_im_x;
                            r_st     <= S_OUT;
                        end
                        OP_CONJ: begin
                            r_acc_re <= a_re_x;
                            r_acc_im <= -a_im_x;
                            r_st     <= S_OUT;
                        end
                        OP_TRACE: begin
                            r_acc_re <= r_acc_re + a_re_x;
                            r_acc_im <= r_acc_im + a_im_x;
                            r_k      <= r_k + 1'b1;
                            r_st     <= (r_k == 2'd2) ? S_OUT : S_RD1;
                        end
                        OP_SCALE: begin
                            r_x_re <= i_job.s_re[EFF-1:0];
                            r_x_im <= i_job.s_im[EFF-1:0];
                            r_y_re <= b_re;
                            r_y_im <= b_im;
                            r_st   <= S_MUL;
                        end
                        OP_MUL: begin
                            r_x_re <= a_re;
                            r_x_im <= a_im;
                            r_y_re <= b_re;
                            r_y_im <= b_im;
                            r_st   <= S_MUL;
                        end
                        OP_DET: begin
                            if (r_ph) begin
                                r_y_re <= a_re;
                                r_y_im <= a_im;
                                r_st   <= S_MUL;
                            end else begin
                                r_x_re <= a_re;
                                r_x_im <= a_im;
                                r_st   <= S_LD2;
                            end
                        end
                        default: r_st <= S_IDLE;
                    endcase
                end
                S_LD2: begin
                    r_y_re <= a_re;
                    r_y_im <= a_im;
                    r_st   <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= mul_a * mul_b;
                    r_st   <= S_ACC;
                end
                S_ACC: begin
                    // first det stage sums into the term register
                    if (is_det && !r_ph) begin
                        if (r_m[1]) begin
                            r_tac_im <= r_tac_im + addend;
                        end else begin
                            r_tac_re <= r_tac_re + addend;
                        end
                    end else if (r_m[1]) begin
                        r_acc_im <= r_acc_im + addend;
                    end else begin
                        r_acc_re <= r_acc_re + addend;
                    end
                    r_m <= r_m + 1'b1;
                    if (r_m != 2'd3) begin
                        r_st <= S_MUL;
                    end else if (i_job.op == OP_MUL) begin
                        r_k  <= r_k + 1'b1;
                        r_st <= (r_k == 2'd2) ? S_OUT : S_RD1;
                    end else if (is_det && !r_ph) begin
                        r_st <= S_TSAT;
                    end else if (is_det) begin
                        r_n      <= r_n + 1'b1;
                        r_ph     <= 1'b0;
                        r_tac_re <= '0;
                        r_tac_im <= '0;
                        r_st     <= (r_n == 3'd5) ? S_OUT : S_RD1;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_TSAT: begin
                    r_x_re <= sat_tr[EFF-1:0];
                    r_x_im <= sat_ti[EFF-1:0];
                    r_flag <= r_flag | sat_tr[EFF] | sat_ti[EFF];
                    r_ph   <= 1'b1;
                    r_st   <= S_RD1;
                end
                S_OUT: begin
                    if (free) begin
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        r_k      <= '0;
                        r_flag   <= 1'b0;
                        if (last_res) begin
                            r_st <= S_IDLE;
                        end else begin
                            if (r_col == 2'd2) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                            r_st <= S_RD1;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_st == S_OUT && free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && free) begin
            r_o.res_re    <= PORT_BITS'($signed(sat_ar[EFF-1:0]));
            r_o.res_im    <= PORT_BITS'($signed(sat_ai[EFF-1:0]));
            r_o.last      <= last_res;
            r_o.saturated <= r_flag | sat_ar[EFF] | sat_ai[EFF];
        end
    end

endmodule
